FILE: hdl/lr_alu_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr_alu_pkg
// shared types, widths and operation codes of the lr35902 alu with flags
// ---------------------------------------------------------------------------
package lr_alu_pkg;

  localparam int unsigned OPCODE_W = 5;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 24;

  typedef logic [OPCODE_W-1:0] opcode_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam opcode_t OP_ADD    = 5'd0;
  localparam opcode_t OP_ADC    = 5'd1;
  localparam opcode_t OP_SUB    = 5'd2;
  localparam opcode_t OP_SBC    = 5'd3;
  localparam opcode_t OP_AND    = 5'd4;
  localparam opcode_t OP_XOR    = 5'd5;
  localparam opcode_t OP_OR     = 5'd6;
  localparam opcode_t OP_CP     = 5'd7;
  localparam opcode_t OP_INC8   = 5'd8;
  localparam opcode_t OP_DEC8   = 5'd9;
  localparam opcode_t OP_INC16  = 5'd10;
  localparam opcode_t OP_DEC16  = 5'd11;
  localparam opcode_t OP_ADD16  = 5'd12;
  localparam opcode_t OP_ADDSP  = 5'd13;
  localparam opcode_t OP_DAA    = 5'd14;
  localparam opcode_t OP_CPL    = 5'd15;
  localparam opcode_t OP_RLCA   = 5'd16;
  localparam opcode_t OP_RLA    = 5'd17;
  localparam opcode_t OP_RRCA   = 5'd18;
  localparam opcode_t OP_RRA    = 5'd19;
  localparam opcode_t OP_RLC    = 5'd20;
  localparam opcode_t OP_RL     = 5'd21;
  localparam opcode_t OP_RRC    = 5'd22;
  localparam opcode_t OP_RR     = 5'd23;
  localparam opcode_t OP_SLA    = 5'd24;
  localparam opcode_t OP_SRL    = 5'd25;
  localparam opcode_t OP_SWAP   = 5'd26;
  localparam opcode_t OP_BIT    = 5'd27;
  localparam opcode_t OP_RES    = 5'd28;
  localparam opcode_t OP_SET    = 5'd29;

  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

endpackage
`default_nettype wire

FILE: hdl/lr35902_alu_with_flags_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr35902_alu_with_flags_unit
// eight-bit cpu alu with a kept z/n/h/c flag register on stream channels
// path: an accepted request passes the input register, then the result register, before out_tvalid rises
// throughput: one request per cycle while the output is not stalled, set by the single alu pass per cycle
// the flag register is read and written in that same pass, in request order
// reset: synchronous rst_n low clears both valid bits and the flag register
// ---------------------------------------------------------------------------
module lr35902_alu_with_flags_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // opcode[4:0], operand_a[20:5], operand_b[36:21], bit_index[39:37]
  input  wire [lr_alu_pkg::IN_W-1:0]     in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // result[15:0], flag_zero[16], flag_subtract[17], flag_half_carry[18],
  // flag_carry[19], zero[23:20]
  output logic [lr_alu_pkg::OUT_W-1:0]   out_tdata
);

  logic                                in_valid_r;
  lr_alu_pkg::opcode_t                 in_op_r;
  logic [lr_alu_pkg::WORD_W-1:0]       in_a_r;
  logic [lr_alu_pkg::WORD_W-1:0]       in_b_r;
  logic [lr_alu_pkg::IDX_W-1:0]        in_idx_r;
  logic                                out_valid_r;
  logic [lr_alu_pkg::WORD_W-1:0]       out_result_r;
  lr_alu_pkg::flags_t                  flags_r;
  logic [lr_alu_pkg::WORD_W-1:0]       result_nxt;
  lr_alu_pkg::flags_t                  flags_nxt;
  logic                                advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r  <= in_tdata[4:0];
      in_a_r   <= in_tdata[20:5];
      in_b_r   <= in_tdata[36:21];
      in_idx_r <= in_tdata[39:37];
    end
  end

  lr_alu_core u_core (
    .op        (in_op_r),
    .a16       (in_a_r),
    .b16       (in_b_r),
    .idx       (in_idx_r),
    .flags_in  (flags_r),
    .result    (result_nxt),
    .flags_out (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= result_nxt;
    end
  end

  // flags_r always matches the request held in the result register
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, flags_r.c, flags_r.h, flags_r.n, flags_r.z, out_result_r};

endmodule
`default_nettype wire

FILE: hdl/lr_alu_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr_alu_core
// combinational datapath: one operation and its new flags from the old ones
// ---------------------------------------------------------------------------
module lr_alu_core (
  input  wire lr_alu_pkg::opcode_t           op,
  input  wire [lr_alu_pkg::WORD_W-1:0]       a16,
  input  wire [lr_alu_pkg::WORD_W-1:0]       b16,
  input  wire [lr_alu_pkg::IDX_W-1:0]        idx,
  input  wire lr_alu_pkg::flags_t            flags_in,
  output logic [lr_alu_pkg::WORD_W-1:0]      result,
  output lr_alu_pkg::flags_t                 flags_out
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        add_cin;
  logic        sub_cin;
  logic [8:0]  sum9;
  logic [4:0]  sum_h;
  logic [8:0]  diff9;
  logic [4:0]  diff_h;
  logic [15:0] wide_b;
  logic [16:0] sum17;
  logic [12:0] sum_h12;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_r;
  logic [7:0]  rot_r;
  logic        rot_c;
  logic [7:0]  bit_mask;
  logic [7:0]  r8;

  assign a       = a16[7:0];
  assign b       = b16[7:0];
  assign add_cin = (op == lr_alu_pkg::OP_ADC) && flags_in.c;
  assign sub_cin = (op == lr_alu_pkg::OP_SBC) && flags_in.c;
  assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
  assign sum_h   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
  assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, sub_cin};
  assign diff_h  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cin};
  // signed byte offset for the stack pointer add
  assign wide_b  = (op == lr_alu_pkg::OP_ADDSP) ? {{8{b[7]}}, b} : b16;
  assign sum17   = {1'b0, a16} + {1'b0, wide_b};
  assign sum_h12 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
  assign inc8    = a + 8'd1;
  assign dec8    = a - 8'd1;
  assign bit_mask = 8'd1 << idx;

  always_comb begin
    daa_hi = 1'b0;
    daa_lo = 1'b0;
    if (flags_in.n) begin
      daa_r = a - (flags_in.c ? lr_alu_pkg::DAA_HI_ADJ : 8'd0)
                - (flags_in.h ? lr_alu_pkg::DAA_LO_ADJ : 8'd0);
    end else begin
      daa_hi = flags_in.c || (a > lr_alu_pkg::DAA_HI_LIM);
      daa_lo = flags_in.h || (a[3:0] > lr_alu_pkg::DAA_LO_LIM);
      daa_r  = a + (daa_hi ? lr_alu_pkg::DAA_HI_ADJ : 8'd0)
                 + (daa_lo ? lr_alu_pkg::DAA_LO_ADJ : 8'd0);
    end
  end

  // rotates: op[1] picks direction, op[0] picks carry-through
  always_comb begin
    if (!op[1]) begin
      rot_c = a[7];
      rot_r = {a[6:0], op[0] ? flags_in.c : a[7]};
    end else begin
      rot_c = a[0];
      rot_r = {op[0] ? flags_in.c : a[0], a[7:1]};
    end
  end

  always_comb begin
    r8        = 8'd0;
    result    = a16;
    flags_out = flags_in;
    case (op)
      lr_alu_pkg::OP_ADD, lr_alu_pkg::OP_ADC: begin
        r8        = sum9[7:0];
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: sum_h[4], c: sum9[8]};
      end
      lr_alu_pkg::OP_SUB, lr_alu_pkg::OP_SBC, lr_alu_pkg::OP_CP: begin
        r8        = diff9[7:0];
        result    = (op == lr_alu_pkg::OP_CP) ? a16 : {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b1, h: diff_h[4], c: diff9[8]};
      end
      lr_alu_pkg::OP_AND: begin
        r8        = a & b;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      lr_alu_pkg::OP_XOR: begin
        r8        = a ^ b;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      lr_alu_pkg::OP_OR: begin
        r8        = a | b;
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      lr_alu_pkg::OP_INC8: begin
        result    = {8'd0, inc8};
        flags_out = '{z: (inc8 == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: flags_in.c};
      end
      lr_alu_pkg::OP_DEC8: begin
        result    = {8'd0, dec8};
        flags_out = '{z: (dec8 == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: flags_in.c};
      end
      lr_alu_pkg::OP_INC16: begin
        result = a16 + 16'd1;
      end
      lr_alu_pkg::OP_DEC16: begin
        result = a16 - 16'd1;
      end
      lr_alu_pkg::OP_ADD16: begin
        result    = sum17[15:0];
        flags_out = '{z: flags_in.z, n: 1'b0, h: sum_h12[12], c: sum17[16]};
      end
      lr_alu_pkg::OP_ADDSP: begin
        result    = sum17[15:0];
        flags_out = '{z: 1'b0, n: 1'b0, h: sum_h[4], c: sum9[8]};
      end
      lr_alu_pkg::OP_DAA: begin
        result    = {8'd0, daa_r};
        flags_out = '{z: (daa_r == 8'd0), n: flags_in.n, h: 1'b0,
                      c: flags_in.c || daa_hi};
      end
      lr_alu_pkg::OP_CPL: begin
        result    = {8'd0, ~a};
        flags_out = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
      end
      lr_alu_pkg::OP_RLCA, lr_alu_pkg::OP_RLA, lr_alu_pkg::OP_RRCA, lr_alu_pkg::OP_RRA,
      lr_alu_pkg::OP_RLC, lr_alu_pkg::OP_RL, lr_alu_pkg::OP_RRC, lr_alu_pkg::OP_RR: begin
        result    = {8'd0, rot_r};
        // accumulator forms clear z
        flags_out = '{z: op[2] && (rot_r == 8'd0), n: 1'b0, h: 1'b0, c: rot_c};
      end
      lr_alu_pkg::OP_SLA: begin
        r8        = {a[6:0], 1'b0};
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      lr_alu_pkg::OP_SRL: begin
        r8        = {1'b0, a[7:1]};
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      lr_alu_pkg::OP_SWAP: begin
        r8        = {a[3:0], a[7:4]};
        result    = {8'd0, r8};
        flags_out = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      lr_alu_pkg::OP_BIT: begin
        flags_out = '{z: ~a[idx], n: 1'b0, h: 1'b1, c: flags_in.c};
      end
      lr_alu_pkg::OP_RES: begin
        result = {8'd0, a & ~bit_mask};
      end
      lr_alu_pkg::OP_SET: begin
        result = {8'd0, a | bit_mask};
      end
      default: begin
        result    = a16;
        flags_out = flags_in;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/lr_alu_chk.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lr_alu_chk
// port-level checks of the lr35902 alu with flags, bound to the top level
// ---------------------------------------------------------------------------
module lr_alu_chk (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire [lr_alu_pkg::IN_W-1:0]     in_tdata,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [lr_alu_pkg::OUT_W-1:0]    out_tdata
);

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !in_tready |-> out_tvalid && !out_tready)
    else $error("request refused without output stall");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0)
    else $error("padding bits of result not zero");

endmodule

bind lr35902_alu_with_flags_unit lr_alu_chk u_lr_alu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
